[hw/rtl/lcd_frame_scan_serializer_defines.svh]
// Assertion macros for the frame scan serializer.
`ifndef LCD_FRAME_SCAN_SERIALIZER_DEFINES_SVH
`define LCD_FRAME_SCAN_SERIALIZER_DEFINES_SVH

// checked outside reset
`define LFSS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define LFSS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/lfss_pkg.sv]
package lfss_pkg;

   localparam int ADDR_WIDTH = 11;
   localparam int ROW_COUNT  = 96;
   localparam int LANE_COUNT = 4;
   localparam int ROW_BYTES  = ROW_COUNT * LANE_COUNT;
   localparam int GROUP_SPAN = 24;

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_TICK  = 1'b1;

   localparam logic [4:0] STEP_LAST  = 5'd24;
   localparam logic [4:0] STEP_SPLIT = 5'd20;
   localparam logic [1:0] LANE_LAST  = 2'd3;
   localparam logic [1:0] GROUP_LAST = 2'd3;
   localparam logic [2:0] BIT_LAST   = 3'd7;
   localparam logic [7:0] SEG_BASE   = 8'h60;

   typedef struct packed {
      logic                  kind;
      logic [ADDR_WIDTH-1:0] address;
      logic [7:0]            value;
   } req_type;

   typedef struct packed {
      logic       data_bit;
      logic       strobe_pulse;
      logic [1:0] strobe_line;
      logic       frame_end;
   } rsp_type;

endpackage

[hw/rtl/lfss_ram.sv]
module lfss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lcd_frame_scan_serializer.sv]
// Output: a tick's result is registered and shows on rsp in the cycle after acceptance.
// Throughput: one item per cycle unless req_stall is high (clearing pass, or a tick while
// rsp is stalled); the next step's frame byte is read ahead from the single-port-read
// frame RAM, with write forwarding into that read. Reset: synchronous; counters and
// output clear, then a clearing pass zeroes all LINE_COUNT*384 (1536 at default) RAM bytes.
module lcd_frame_scan_serializer #(
   parameter int LINE_COUNT = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lfss_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lfss_pkg::rsp_type rsp_item
);

   localparam int STORE_SIZE = LINE_COUNT * lfss_pkg::ROW_BYTES;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam logic [1:0] LINE_LAST = 2'(LINE_COUNT - 1);

   typedef enum logic [1:0] {PH_DATA, PH_SEG, PH_STROBE} phase_type;

   phase_type phase_ff, phase_in;
   logic [1:0] line_ff, line_in;
   logic [1:0] lane_ff, lane_in;
   logic [1:0] group_ff, group_in;
   logic [4:0] step_ff, step_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] shift_ff, shift_in;

   logic              rsp_valid_ff;
   lfss_pkg::rsp_type rsp_item_ff;
   lfss_pkg::rsp_type res;

   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          byp_valid_ff;
   logic [7:0]    byp_data_ff;
   logic          rd_zero_ff;

   logic          out_ready, req_fire, tick, wr;
   logic          advance;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic [7:0]    row;
   logic [7:0]    cur, payload, seg;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clr_busy_ff || ((req_item.kind == lfss_pkg::KIND_TICK) && !out_ready);
   assign req_fire  = req_valid && !req_stall;
   assign tick      = req_fire && (req_item.kind == lfss_pkg::KIND_TICK);
   assign wr        = req_fire && (req_item.kind == lfss_pkg::KIND_WRITE)
                      && (req_item.address < lfss_pkg::ADDR_WIDTH'(STORE_SIZE));

   assign cur = rd_zero_ff ? 8'h00 : (byp_valid_ff ? byp_data_ff : ram_rdata);
   assign seg = lfss_pkg::SEG_BASE | 8'({lane_ff, 2'b00});

   always_comb begin
      if (step_ff < lfss_pkg::STEP_SPLIT) begin
         payload = cur;
      end else if (step_ff == lfss_pkg::STEP_SPLIT) begin
         payload = {cur[3:0], 4'h0};
      end else if (step_ff < lfss_pkg::STEP_LAST) begin
         payload = {cur[3:0], prev_ff[7:4]};
      end else begin
         payload = {4'h0, prev_ff[7:4]};
      end
   end

   always_comb begin
      line_in  = line_ff;
      lane_in  = lane_ff;
      group_in = group_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      shift_in = shift_ff;
      advance  = 1'b0;
      res              = '0;
      res.strobe_line  = line_ff;
      if (tick) begin
         case (phase_ff)
            PH_STROBE: begin
               res.strobe_pulse = 1'b1;
               res.frame_end    = (line_ff == LINE_LAST) && (lane_ff == lfss_pkg::LANE_LAST);
               lane_in          = lane_ff + 2'd1;
               if (lane_ff == lfss_pkg::LANE_LAST) begin
                  line_in = (line_ff == LINE_LAST) ? 2'd0 : line_ff + 2'd1;
               end
               phase_in = PH_DATA;
               bit_in   = 3'd0;
            end
            PH_SEG: begin
               res.data_bit = seg[bit_ff];
               bit_in       = bit_ff + 3'd1;
               advance      = (bit_ff == lfss_pkg::BIT_LAST);
            end
            default: begin
               if (bit_ff == 3'd0) begin
                  shift_in     = payload;
                  prev_in      = cur;
                  res.data_bit = payload[0];
               end else begin
                  res.data_bit = shift_ff[bit_ff];
               end
               bit_in = bit_ff + 3'd1;
               if (bit_ff == lfss_pkg::BIT_LAST) begin
                  if (step_ff inside {5'd4, 5'd9, 5'd14, 5'd19, 5'd24}) begin
                     phase_in = PH_SEG;
                  end else begin
                     advance = 1'b1;
                  end
               end
            end
         endcase
      end
      if (advance) begin
         step_in  = step_ff + 5'd1;
         phase_in = PH_DATA;
         if (step_ff == lfss_pkg::STEP_LAST) begin
            step_in  = 5'd0;
            group_in = group_ff + 2'd1;
            if (group_ff == lfss_pkg::GROUP_LAST) begin
               phase_in = PH_STROBE;
            end
         end
      end
   end

   // read the byte of the step that the next state points at
   assign row = 8'(lfss_pkg::ROW_COUNT - 1) - 8'(group_in) * 8'(lfss_pkg::GROUP_SPAN)
                - 8'(step_in);
   assign ram_raddr = AW'(11'({row[6:0], lane_in}) + 11'(line_in) * 11'(lfss_pkg::ROW_BYTES));

   assign ram_we    = clr_busy_ff || wr;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : AW'(req_item.address);
   assign ram_wdata = clr_busy_ff ? 8'h00 : req_item.value;

   lfss_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         line_ff      <= 2'd0;
         lane_ff      <= 2'd0;
         group_ff     <= 2'd0;
         step_ff      <= 5'd0;
         bit_ff       <= 3'd0;
         prev_ff      <= 8'h00;
         shift_ff     <= 8'h00;
         rsp_valid_ff <= 1'b0;
         rsp_item_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         lane_ff  <= lane_in;
         group_ff <= group_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         prev_ff  <= prev_in;
         shift_ff <= shift_in;
         if (tick) begin
            rsp_valid_ff <= 1'b1;
            rsp_item_ff  <= res;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // clearing pass and write-to-read forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         byp_valid_ff <= 1'b0;
         rd_zero_ff   <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_SIZE - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         byp_valid_ff <= ram_we && (ram_waddr == ram_raddr);
         rd_zero_ff   <= row[7];
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= ram_wdata;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[hw/rtl/lfss_checker.sv]
`include "lcd_frame_scan_serializer_defines.svh"

module lfss_checker #(
   parameter int LINE_COUNT = 4
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lfss_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lfss_pkg::rsp_type rsp_item
);

   logic [1:0] line_top;

   assign line_top = 2'(LINE_COUNT - 1);

   `LFSS_ASSERT_ALWAYS(a_clear_after_reset, reset |=> req_stall && !rsp_valid, "frame clear not held after reset")
   `LFSS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled item changed")
   `LFSS_ASSERT(a_frame_end_strobe, rsp_valid && rsp_item.frame_end |-> rsp_item.strobe_pulse && rsp_item.strobe_line == line_top, "frame end off last line strobe")
   `LFSS_ASSERT(a_strobe_no_bit, rsp_valid && rsp_item.strobe_pulse |-> !rsp_item.data_bit, "data bit set on strobe")
   `LFSS_ASSERT(a_line_range, rsp_valid |-> rsp_item.strobe_line <= line_top, "line out of range")

endmodule

bind lcd_frame_scan_serializer lfss_checker #(.LINE_COUNT(LINE_COUNT)) u_lfss_checker (.*);
